// ----- src/bbc_pkg.sv -----
package bbc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_BALANCED = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNCLOSED = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              balanced;
    } t_result;

    function automatic logic [KIND_W-1:0] open_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] close_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- src/bbc_ram.sv -----
module bbc_ram #(
    parameter int P_WIDTH = 2,
    parameter int P_DEPTH = 32,
    parameter int P_AW    = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [P_AW-1:0]    i_waddr,
    input  logic [P_WIDTH-1:0] i_wdata,
    input  logic [P_AW-1:0]    i_raddr,
    output logic [P_WIDTH-1:0] o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bbc_stack_ctrl.sv -----
module bbc_stack_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [bbc_pkg::CHAR_W-1:0] i_char_in,
    input  logic                   i_last_char,
    output logic                   o_res_valid,
    output bbc_pkg::t_result       o_res
);
    import bbc_pkg::*;

    logic [STACK_CW-1:0] r_count, n_count;
    logic [STAT_W-1:0]   r_err, n_err;
    logic                r_byp;
    logic [KIND_W-1:0]   r_byp_data;

    logic                we;
    logic [STACK_AW-1:0] waddr, raddr;
    logic [KIND_W-1:0]   wdata, rdata, top;
    logic [KIND_W-1:0]   ok, ck;
    logic [STACK_CW-1:0] cnt_post;
    logic [STAT_W-1:0]   err_post, status;

    bbc_ram #(
        .P_WIDTH (KIND_W),
        .P_DEPTH (STACK_DEPTH),
        .P_AW    (STACK_AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // top entry was read last cycle; a push in the same cycle bypasses the RAM
    assign top = r_byp ? r_byp_data : rdata;
    assign ok  = open_kind(i_char_in);
    assign ck  = close_kind(i_char_in);

    always_comb begin
        we       = 1'b0;
        waddr    = r_count[STACK_AW-1:0];
        wdata    = ok;
        cnt_post = r_count;
        err_post = r_err;
        if (i_take && r_err == ST_BALANCED) begin
            if (ok != KIND_NONE) begin
                if (r_count == STACK_CW'(STACK_DEPTH)) begin
                    err_post = ST_OVERFLOW;
                end else begin
                    we       = 1'b1;
                    cnt_post = r_count + 1'b1;
                end
            end else if (ck != KIND_NONE) begin
                if (r_count == '0) begin
                    err_post = ST_MISMATCH;
                end else if (top == ck) begin
                    cnt_post = r_count - 1'b1;
                end else begin
                    err_post = ST_MISMATCH;
                end
            end
        end

        if (err_post != ST_BALANCED) begin
            status = err_post;
        end else if (cnt_post != '0) begin
            status = ST_UNCLOSED;
        end else begin
            status = ST_BALANCED;
        end

        n_count = cnt_post;
        n_err   = err_post;
        if (i_take && i_last_char) begin
            n_count = '0;
            n_err   = ST_BALANCED;
        end

        // fetch the entry that will be on top next cycle
        raddr = STACK_AW'(n_count - 1'b1);
    end

    assign o_res_valid     = i_take && i_last_char;
    assign o_res.status    = status;
    assign o_res.balanced  = (status == ST_BALANCED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= ST_BALANCED;
            r_byp   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            r_byp   <= we && (waddr == raddr);
        end
        r_byp_data <= wdata;
    end

endmodule

// ----- src/bbc_out_buf.sv -----
module bbc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bbc_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output bbc_pkg::t_result o_res
);
    import bbc_pkg::*;

    logic    r_head_v, r_skid_v;
    t_result r_head, r_skid;
    logic    pop;

    assign pop     = r_head_v && i_ready;
    assign o_full  = r_skid_v;
    assign o_valid = r_head_v;
    assign o_res   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_head_v || pop) begin
                if (r_skid_v) begin
                    r_head_v <= 1'b1;
                    r_skid_v <= i_push;
                end else begin
                    r_head_v <= i_push;
                end
            end else if (i_push) begin
                r_skid_v <= 1'b1;
            end
        end

        if (!r_head_v || pop) begin
            if (r_skid_v) begin
                r_head <= r_skid;
                if (i_push) begin
                    r_skid <= i_res;
                end
            end else if (i_push) begin
                r_head <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

// ----- src/bracket_balance_checker_unit.sv -----
// Channel  Valid     Ready     Payload
// input    i_valid   o_ready   i_char_in, i_last_char
// output   o_valid   i_ready   o_status, o_balanced
//
// One byte per cycle: the stack top is read from the RAM beforehand,
// with a write-to-read bypass when a push lands on the entry being fetched.
// A status beat is registered into the output buffer with the last byte.
// Reset clears depth and error; stack RAM contents are not cleared.
// Input stalls only when both output stages hold beats.
module bracket_balance_checker_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bbc_pkg::CHAR_W-1:0] i_char_in,
    input  logic                       i_last_char,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bbc_pkg::STAT_W-1:0] o_status,
    output logic                       o_balanced
);
    import bbc_pkg::*;

    logic    take, res_valid, full;
    t_result res, out_res;

    assign o_ready = !full;
    assign take    = i_valid && !full;

    bbc_stack_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bbc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_status   = out_res.status;
    assign o_balanced = out_res.balanced;

endmodule

// ----- test/tb_bracket_balance_checker_unit.sv -----
module tb_bracket_balance_checker_unit;

    import bbc_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_OFF     = 300;
    localparam int RANDOM_BYTES = 780;
    localparam int DRAIN_CYCLES = 20;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic [CHAR_W-1:0]   i_char_in   = '0;
    logic                i_last_char = 1'b0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic                o_balanced;

    bracket_balance_checker_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_balanced  (o_balanced)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [KIND_W-1:0] open_stack [STACK_DEPTH];
    int                open_depth = 0;
    logic [STAT_W-1:0] sticky_err = ST_BALANCED;

    t_result           expected_status_q [$];
    logic [CHAR_W-1:0] text_buf [$];

    int  fail_count  = 0;
    int  bytes_sent  = 0;
    int  beats_seen  = 0;
    int  status_hits [4];
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  src_steady  = 1'b0;
    bit  sink_steady = 1'b0;

    t_result seen_exp;

    function automatic logic [CHAR_W-1:0] bracket_char(input logic [KIND_W-1:0] kind,
                                                       input bit closing);
        logic [CHAR_W-1:0] c;
        case (kind)
            KIND_ROUND:  c = closing ? CH_CLOSE_ROUND  : CH_OPEN_ROUND;
            KIND_SQUARE: c = closing ? CH_CLOSE_SQUARE : CH_OPEN_SQUARE;
            default:     c = closing ? CH_CLOSE_CURLY  : CH_OPEN_CURLY;
        endcase
        return c;
    endfunction

    // Advance the predictor by one byte; returns 1 when a status beat is due.
    function automatic bit predict_status(input logic [CHAR_W-1:0] c, input logic last,
                                          output t_result r);
        logic [KIND_W-1:0] opener;
        logic [KIND_W-1:0] closer;
        opener = KIND_NONE;
        closer = KIND_NONE;
        if (c == CH_OPEN_ROUND)   opener = KIND_ROUND;
        if (c == CH_OPEN_SQUARE)  opener = KIND_SQUARE;
        if (c == CH_OPEN_CURLY)   opener = KIND_CURLY;
        if (c == CH_CLOSE_ROUND)  closer = KIND_ROUND;
        if (c == CH_CLOSE_SQUARE) closer = KIND_SQUARE;
        if (c == CH_CLOSE_CURLY)  closer = KIND_CURLY;
        r = '0;
        // first error sticks; later brackets are dropped
        if (sticky_err == ST_BALANCED) begin
            if (opener != KIND_NONE) begin
                if (open_depth >= STACK_DEPTH) begin
                    sticky_err = ST_OVERFLOW;
                end else begin
                    open_stack[open_depth] = opener;
                    open_depth++;
                end
            end else if (closer != KIND_NONE) begin
                if (open_depth == 0) begin
                    sticky_err = ST_MISMATCH;
                end else if (open_stack[open_depth-1] == closer) begin
                    open_depth--;
                end else begin
                    sticky_err = ST_MISMATCH;
                end
            end
        end
        if (!last) return 1'b0;
        if (sticky_err != ST_BALANCED) r.status = sticky_err;
        else if (open_depth != 0)      r.status = ST_UNCLOSED;
        else                           r.status = ST_BALANCED;
        r.balanced = (r.status == ST_BALANCED);
        open_depth = 0;
        sticky_err = ST_BALANCED;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
        int      gap;
        t_result r;
        gap = 0;
        if (!src_steady) begin
            while ($urandom_range(0, 99) < 21) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_in   <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (predict_status(c, last, r)) expected_status_q.push_back(r);
    endtask

    // Send the buffered text as one string, last flag on the final byte.
    task automatic send_text;
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++) send_byte(text_buf[i], i == n - 1);
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        send_string("()");
        send_string("([{}])");
        send_string("[}");
        send_string(")");
        send_string("((");
        send_string("((]");
        send_string("(])");
        send_string("(x");
        send_string("a");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_stack_limits;
        logic [KIND_W-1:0] kinds [$];
        // full depth, then close everything
        for (int i = 0; i < STACK_DEPTH; i++) kinds.push_back(KIND_W'($urandom_range(0, 2)));
        foreach (kinds[i]) text_buf.push_back(bracket_char(kinds[i], 1'b0));
        for (int i = STACK_DEPTH - 1; i >= 0; i--) text_buf.push_back(bracket_char(kinds[i], 1'b1));
        send_text();
        // full depth left open
        foreach (kinds[i]) text_buf.push_back(bracket_char(kinds[i], 1'b0));
        send_text();
        // one past full, then a closer that must be ignored
        foreach (kinds[i]) text_buf.push_back(bracket_char(kinds[i], 1'b0));
        text_buf.push_back(CH_OPEN_CURLY);
        text_buf.push_back(bracket_char(kinds[STACK_DEPTH-1], 1'b1));
        send_text();
        wait_drained();
    endtask

    task automatic test_backpressure;
        hold_cycles = HOLD_OFF;
        for (int i = 0; i < 16; i++) begin
            if ($urandom_range(0, 1)) send_byte(bracket_char(KIND_W'($urandom_range(0, 2)),
                                                             1'($urandom_range(0, 1))), 1'b1);
            else send_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
        end
        wait_drained();
    endtask

    task automatic build_random_text;
        logic [KIND_W-1:0] opened [$];
        int                target;
        int                p;
        bit                built;
        logic [KIND_W-1:0] k;
        if ($urandom_range(0, 99) < 75) begin
            // well-formed core with random content and an occasional broken end
            target = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 6);
            built  = 1'b0;
            while (!built || opened.size() != 0) begin
                p = $urandom_range(0, 99);
                if (p < 12) begin
                    text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                end else if (!built && (opened.size() == 0 || p >= 30)) begin
                    k = KIND_W'($urandom_range(0, 2));
                    opened.push_back(k);
                    text_buf.push_back(bracket_char(k, 1'b0));
                    if (opened.size() >= target) built = 1'b1;
                end else begin
                    if (built && $urandom_range(0, 99) < 3) break;
                    text_buf.push_back(bracket_char(opened.pop_back(), 1'b1));
                end
            end
            p = $urandom_range(0, 99);
            if (p < 8) begin
                text_buf.push_back(bracket_char(KIND_W'($urandom_range(0, 2)), 1'b0));
            end else if (p < 16) begin
                k = (opened.size() != 0) ? opened[$] : KIND_ROUND;
                text_buf.push_back(bracket_char((k == KIND_CURLY) ? KIND_ROUND
                                                                  : KIND_W'(k + 1'b1), 1'b1));
            end
        end else begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 1))
                    text_buf.push_back(bracket_char(KIND_W'($urandom_range(0, 2)),
                                                    1'($urandom_range(0, 1))));
                else
                    text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        end
        if (text_buf.size() == 0) text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random;
        int stop_at;
        int steady_until;
        stop_at      = bytes_sent + RANDOM_BYTES;
        steady_until = bytes_sent + 150;
        src_steady   = 1'b1;
        sink_steady  = 1'b1;
        while (bytes_sent < stop_at) begin
            if (bytes_sent >= steady_until) begin
                src_steady  = 1'b0;
                sink_steady = 1'b0;
            end
            build_random_text();
            send_text();
        end
        wait_drained();
    endtask

    // receiver: random idling, steady stretches, and a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles--;
        end else if (sink_steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            beats_seen++;
            status_hits[o_status]++;
            if (expected_status_q.size() == 0) begin
                $error("unexpected status beat: status=%0d balanced=%0b", o_status, o_balanced);
                fail_count++;
            end else begin
                seen_exp = expected_status_q.pop_front();
                if (o_status !== seen_exp.status) begin
                    $error("status: expected %0d, got %0d", seen_exp.status, o_status);
                    fail_count++;
                end
                if (o_balanced !== seen_exp.balanced) begin
                    $error("balanced: expected %0b, got %0b", seen_exp.balanced, o_balanced);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        foreach (status_hits[i]) status_hits[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_stack_limits();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_status_q.size() != 0) begin
            $error("%0d status beats never arrived", expected_status_q.size());
            fail_count++;
        end

        $display("Checked %0d bytes, %0d status beats in %0d cycles",
                 bytes_sent, beats_seen, cycle_count);
        $display("  balanced %0d, mismatch %0d, unclosed %0d, overflow %0d",
                 status_hits[ST_BALANCED], status_hits[ST_MISMATCH],
                 status_hits[ST_UNCLOSED], status_hits[ST_OVERFLOW]);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
